// ===== sv/lzwd_pkg.sv =====
// Shared types and constants for the LZW variable-width decoder.
package lzwd_pkg;

  localparam logic [11:0] CODE_CLEAR = 12'h100;
  localparam logic [11:0] CODE_END   = 12'h101;
  localparam logic [12:0] FIRST_FREE = 13'h102;
  localparam logic [3:0]  MIN_WIDTH  = 4'd9;
  localparam logic [3:0]  MAX_WIDTH  = 4'd12;
  localparam logic [3:0]  CFG_RESET  = 4'hB;

  localparam logic [1:0]  STAT_OK    = 2'd0;
  localparam logic [1:0]  STAT_END   = 2'd1;
  localparam logic [1:0]  STAT_LONG  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_CLASS, S_LIT, S_END, S_WALK, S_WAIT, S_ERR, S_POPRD, S_POPOUT
  } state_t;

  typedef enum logic [1:0] {
    OSEL_LIT, OSEL_END, OSEL_ERR, OSEL_STACK
  } osel_t;

  typedef struct packed {
    logic  accept;
    logic  extract;
    logic  clear;
    logic  walk_init;
    logic  rd_issue;
    logic  rd_push;
    logic  finish;
    logic  pop_rd;
    logic  load;
    osel_t sel;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic have_code;
    logic after_clear;
    logic is_end;
    logic is_clear;
    logic cur_literal;
    logic stack_full;
    logic depth_zero;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/lzw_variable_width_decoder_core.sv =====
// LZW variable-width decoder top level: sequencer plus datapath.
// Each input byte is accepted in idle and checked for a complete code; a clear code
// is then classified, and a literal after a clear or the end code is classified and its
// result registered. A string is classified, its chain walked one dictionary read at a
// time, and each byte read from the stack and then loaded. Output stalls hold the load.
// One item is worked on at a time. Synchronous active-low reset clears control state only.
module lzw_variable_width_decoder_core #(
  parameter int DICT_DEPTH  = 4096,
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last,
  output logic [1:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_max_code_bits
);
  import lzwd_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  lzwd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  lzwd_dp #(
    .DICT_DEPTH  (DICT_DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_data_byte       (in_data_byte),
    .in_first_of_stream (in_first_of_stream),
    .cfg_valid          (cfg_valid),
    .cfg_max_code_bits  (cfg_max_code_bits),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_last           (out_last),
    .out_status         (out_status)
  );

endmodule

// ===== sv/lzwd_ctrl.sv =====
// Sequencer for code extraction, chain walk and byte emission.
module lzwd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lzwd_pkg::stat_t st,
  output lzwd_pkg::cmd_t  cmd
);
  import lzwd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_CHECK;
      S_CHECK:  state_nxt = (st.halted || !st.have_code) ? S_IDLE : S_CLASS;
      S_CLASS: begin
        priority if (st.after_clear) state_nxt = S_LIT;
        else if (st.is_end)          state_nxt = S_END;
        else if (st.is_clear)        state_nxt = S_IDLE;
        else                         state_nxt = S_WALK;
      end
      S_LIT:    if (st.out_free) state_nxt = S_IDLE;
      S_END:    if (st.out_free) state_nxt = S_IDLE;
      S_ERR:    if (st.out_free) state_nxt = S_IDLE;
      S_WALK: begin
        priority if (st.stack_full) state_nxt = S_ERR;
        else if (st.cur_literal)    state_nxt = S_POPRD;
        else                        state_nxt = S_WAIT;
      end
      S_WAIT:   state_nxt = S_WALK;
      S_POPRD:  state_nxt = S_POPOUT;
      S_POPOUT: if (st.out_free) state_nxt = st.depth_zero ? S_IDLE : S_POPRD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.sel  = OSEL_STACK;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_CHECK:  cmd.extract = !st.halted && st.have_code;
      S_CLASS: begin
        cmd.clear     = !st.after_clear && !st.is_end && st.is_clear;
        cmd.walk_init = !st.after_clear && !st.is_end && !st.is_clear;
      end
      S_LIT: begin
        cmd.load = st.out_free;
        cmd.sel  = OSEL_LIT;
      end
      S_END: begin
        cmd.load = st.out_free;
        cmd.sel  = OSEL_END;
      end
      S_ERR: begin
        cmd.load = st.out_free;
        cmd.sel  = OSEL_ERR;
      end
      S_WALK: begin
        cmd.rd_issue = !st.stack_full && !st.cur_literal;
        cmd.finish   = !st.stack_full && st.cur_literal;
      end
      S_WAIT:   cmd.rd_push = 1'b1;
      S_POPRD:  cmd.pop_rd = 1'b1;
      S_POPOUT: cmd.load = st.out_free;
      default: ;
    endcase
  end

endmodule

// ===== sv/lzwd_dp.sv =====
// Datapath: bit gathering, dictionary, string stack and output register.
module lzwd_dp #(
  parameter int DICT_DEPTH  = 4096,
  parameter int STACK_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lzwd_pkg::cmd_t  cmd,
  output lzwd_pkg::stat_t st,
  input  logic [7:0]      in_data_byte,
  input  logic            in_first_of_stream,
  input  logic            cfg_valid,
  input  logic [3:0]      cfg_max_code_bits,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_last,
  output logic [1:0]      out_status
);
  import lzwd_pkg::*;

  localparam int DAW = $clog2(DICT_DEPTH);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SDW = $clog2(STACK_DEPTH + 1);
  localparam logic [12:0] DICT_END  = 13'(DICT_DEPTH);
  localparam logic [SDW-1:0] SFULL  = SDW'(STACK_DEPTH);

  logic [19:0] dict_mem [DICT_DEPTH];
  logic [7:0]  stack_mem [STACK_DEPTH];

  logic [3:0]  max_bits_r;
  logic [18:0] buf_r;
  logic [4:0]  cnt_r;
  logic [3:0]  width_r;
  logic [12:0] next_r;
  logic [11:0] prev_r;
  logic [7:0]  prev_first_r;
  logic        after_clear_r;
  logic        halted_r;
  logic [11:0] code_r;
  logic [11:0] cur_r;
  logic [SDW-1:0] depth_r;
  logic        oob_r;
  logic [19:0] dict_q_r;
  logic [7:0]  stack_q_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_bv_r;
  logic        out_last_r;
  logic [1:0]  out_status_r;

  logic [18:0] base_buf;
  logic [4:0]  base_cnt;
  logic        base_halt;
  logic [12:0] mask;
  logic [11:0] code_nxt;
  logic [3:0]  maxw;
  logic [12:0] next_nxt;
  logic [19:0] entry;
  logic        push;
  logic [7:0]  push_data;
  logic [SAW-1:0] push_addr;
  logic        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign base_buf  = in_first_of_stream ? 19'd0 : buf_r;
  assign base_cnt  = in_first_of_stream ? 5'd0 : cnt_r;
  assign base_halt = in_first_of_stream ? 1'b0 : halted_r;
  assign mask      = (13'd1 << width_r) - 13'd1;
  assign code_nxt  = buf_r[11:0] & mask[11:0];
  assign next_nxt  = next_r + 13'd1;
  assign entry     = oob_r ? 20'd0 : dict_q_r;

  always_comb begin
    maxw = max_bits_r;
    if (max_bits_r < MIN_WIDTH) maxw = MIN_WIDTH;
    if (max_bits_r > MAX_WIDTH) maxw = MAX_WIDTH;
  end

  always_comb begin
    push      = 1'b0;
    push_data = cur_r[7:0];
    push_addr = depth_r[SAW-1:0];
    if (cmd.walk_init && ({1'b0, code_r} >= next_r)) begin
      // undefined code: the previous string's first byte is this string's last and lands at the bottom of the stack
      push      = 1'b1;
      push_data = prev_first_r;
      push_addr = '0;
    end else if (cmd.rd_push) begin
      push      = 1'b1;
      push_data = entry[7:0];
    end else if (cmd.finish) begin
      push      = 1'b1;
      push_data = cur_r[7:0];
    end
  end

  always_comb begin
    st.halted      = halted_r;
    st.have_code   = {1'b0, cnt_r} >= {2'b0, width_r};
    st.after_clear = after_clear_r;
    st.is_end      = code_r == CODE_END;
    st.is_clear    = code_r == CODE_CLEAR;
    st.cur_literal = cur_r[11:8] == 4'd0;
    st.stack_full  = depth_r >= SFULL;
    st.depth_zero  = depth_r == '0;
    st.out_free    = out_free;
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) dict_q_r <= dict_mem[cur_r[DAW-1:0]];
    if (cmd.finish && next_r < DICT_END) dict_mem[next_r[DAW-1:0]] <= {prev_r, cur_r[7:0]};
    if (push) stack_mem[push_addr] <= push_data;
    if (cmd.pop_rd) stack_q_r <= stack_mem[SAW'(depth_r - SDW'(1))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bits_r    <= CFG_RESET;
      buf_r         <= '0;
      cnt_r         <= '0;
      width_r       <= MIN_WIDTH;
      next_r        <= FIRST_FREE;
      prev_r        <= '0;
      prev_first_r  <= '0;
      after_clear_r <= 1'b0;
      halted_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) max_bits_r <= cfg_max_code_bits;
      if (cmd.load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      if (cmd.accept) begin
        if (in_first_of_stream) begin
          width_r       <= MIN_WIDTH;
          next_r        <= FIRST_FREE;
          prev_r        <= '0;
          prev_first_r  <= '0;
          after_clear_r <= 1'b0;
          halted_r      <= 1'b0;
        end
        if (!base_halt) begin
          buf_r <= base_buf | (19'(in_data_byte) << base_cnt);
          cnt_r <= base_cnt + 5'd8;
        end else begin
          buf_r <= base_buf;
          cnt_r <= base_cnt;
        end
      end

      if (cmd.extract) begin
        code_r <= code_nxt;
        buf_r  <= buf_r >> width_r;
        cnt_r  <= cnt_r - {1'b0, width_r};
      end

      if (cmd.clear) begin
        next_r        <= FIRST_FREE;
        width_r       <= MIN_WIDTH;
        after_clear_r <= 1'b1;
      end

      if (cmd.walk_init) begin
        // code not yet defined: KwKwK, starts with previous string's first byte
        if ({1'b0, code_r} >= next_r) begin
          depth_r <= SDW'(1);
          cur_r   <= prev_r;
        end else begin
          depth_r <= '0;
          cur_r   <= code_r;
        end
      end

      if (cmd.rd_issue) oob_r <= {1'b0, cur_r} >= DICT_END;

      if (cmd.rd_push) begin
        depth_r <= depth_r + SDW'(1);
        cur_r   <= entry[19:8];
      end

      if (cmd.finish) begin
        depth_r      <= depth_r + SDW'(1);
        prev_r       <= code_r;
        prev_first_r <= cur_r[7:0];
        if (next_r < DICT_END) begin
          next_r <= next_nxt;
          if (next_nxt >= (13'd1 << width_r) && width_r < maxw) width_r <= width_r + 4'd1;
        end
      end

      if (cmd.pop_rd) depth_r <= depth_r - SDW'(1);

      if (cmd.load) begin
        unique case (cmd.sel)
          OSEL_LIT: begin
            after_clear_r <= 1'b0;
            prev_r        <= code_r;
            prev_first_r  <= code_r[7:0];
          end
          OSEL_END, OSEL_ERR: halted_r <= 1'b1;
          OSEL_STACK: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      unique case (cmd.sel)
        OSEL_LIT: begin
          out_byte_r   <= code_r[7:0];
          out_bv_r     <= 1'b1;
          out_last_r   <= 1'b1;
          out_status_r <= STAT_OK;
        end
        OSEL_END: begin
          out_byte_r   <= '0;
          out_bv_r     <= 1'b0;
          out_last_r   <= 1'b1;
          out_status_r <= STAT_END;
        end
        OSEL_ERR: begin
          out_byte_r   <= '0;
          out_bv_r     <= 1'b0;
          out_last_r   <= 1'b1;
          out_status_r <= STAT_LONG;
        end
        OSEL_STACK: begin
          out_byte_r   <= stack_q_r;
          out_bv_r     <= 1'b1;
          out_last_r   <= depth_r == '0;
          out_status_r <= STAT_OK;
        end
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the LZW variable-width decoder core: stream encoder, predictor and checker.
module tb_top;
  import lzwd_pkg::*;

  localparam int DICT_SIZE   = 4096;
  localparam int STACK_SIZE  = 64;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE      = 24;

  typedef struct packed {
    logic [7:0] data;
    logic       data_ok;
    logic       last;
    logic [1:0] status;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'd0;
  logic       in_first_of_stream = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_last;
  logic [1:0] out_status;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_max_code_bits = 4'd0;

  lzw_variable_width_decoder_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_first_of_stream(in_first_of_stream),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .out_byte_valid(out_byte_valid),
    .out_last(out_last), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_max_code_bits(cfg_max_code_bits)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  decoded_t expected_bytes[$];
  int  errors = 0;
  int  items_sent = 0;
  bit  idle_on = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  quiet = 0;

  // decoder state as predicted
  logic [3:0]  dec_max_bits;
  int unsigned dec_buf, dec_count, dec_width, dec_next, dec_prev, dec_first_char;
  bit          dec_after_clear, dec_halted;
  logic [19:0] dec_dict[DICT_SIZE];
  logic [7:0]  dec_stack[STACK_SIZE];

  // encoder view used to build legal streams
  int unsigned enc_next, enc_width, enc_prev_len, enc_acc, enc_nbits;
  bit          enc_after_clear, enc_halted, enc_first;
  int unsigned enc_len[DICT_SIZE];

  function automatic int unsigned clamp_width(input logic [3:0] v);
    if (v < MIN_WIDTH) return MIN_WIDTH;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return v;
  endfunction

  function automatic void restart_decoder();
    dec_buf = 0;
    dec_count = 0;
    dec_width = MIN_WIDTH;
    dec_next = FIRST_FREE;
    dec_prev = 0;
    dec_first_char = 0;
    dec_after_clear = 1'b0;
    dec_halted = 1'b0;
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic ok, input logic lst,
                                    input logic [1:0] st);
    decoded_t r;
    r.data = b;
    r.data_ok = ok;
    r.last = lst;
    r.status = st;
    expected_bytes.push_back(r);
  endfunction

  function automatic void expand_string(input int unsigned code);
    int unsigned depth, cur;
    logic [19:0] e;
    logic [7:0]  first;
    depth = 0;
    cur = code;
    if (code >= dec_next) begin
      dec_stack[0] = dec_first_char[7:0];
      depth = 1;
      cur = dec_prev;
    end
    while (cur > 255) begin
      if (depth >= STACK_SIZE) begin
        dec_halted = 1'b1;
        push_byte(8'd0, 1'b0, 1'b1, STAT_LONG);
        return;
      end
      e = (cur < DICT_SIZE) ? dec_dict[cur] : 20'd0;
      dec_stack[depth] = e[7:0];
      depth++;
      cur = e[19:8];
    end
    if (depth >= STACK_SIZE) begin
      dec_halted = 1'b1;
      push_byte(8'd0, 1'b0, 1'b1, STAT_LONG);
      return;
    end
    first = cur[7:0];
    dec_stack[depth] = first;
    depth++;
    if (dec_next < DICT_SIZE) begin
      dec_dict[dec_next] = {dec_prev[11:0], first};
      dec_next++;
      if (dec_next >= (1 << dec_width) && dec_width < clamp_width(dec_max_bits))
        dec_width++;
    end
    dec_prev = code & 12'hFFF;
    dec_first_char = first;
    while (depth > 0) begin
      depth--;
      push_byte(dec_stack[depth], 1'b1, depth == 0, STAT_OK);
    end
  endfunction

  function automatic void predict_item(input logic [7:0] d, input logic first);
    int unsigned code;
    if (first) restart_decoder();
    if (dec_halted) return;
    dec_buf = dec_buf | (int'(d) << dec_count);
    dec_count += 8;
    if (dec_count < dec_width) return;
    code = dec_buf & ((1 << dec_width) - 1);
    dec_buf = (dec_buf >> dec_width) & 32'h7FFFF;
    dec_count -= dec_width;
    if (dec_after_clear) begin
      dec_after_clear = 1'b0;
      dec_prev = code & 12'hFFF;
      dec_first_char = code & 8'hFF;
      push_byte(code[7:0], 1'b1, 1'b1, STAT_OK);
    end else if (code == CODE_END) begin
      dec_halted = 1'b1;
      push_byte(8'd0, 1'b0, 1'b1, STAT_END);
    end else if (code == CODE_CLEAR) begin
      dec_next = FIRST_FREE;
      dec_width = MIN_WIDTH;
      dec_after_clear = 1'b1;
    end else begin
      expand_string(code);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  task automatic send_item(input logic [7:0] d, input logic first);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_first_of_stream <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    predict_item(d, first);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_max_bits(input logic [3:0] v);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_max_code_bits <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    dec_max_bits = v;
  endtask

  task automatic stream_begin();
    enc_next = FIRST_FREE;
    enc_width = MIN_WIDTH;
    enc_prev_len = 1;
    enc_after_clear = 1'b0;
    enc_halted = 1'b0;
    enc_first = 1'b1;
    enc_acc = 0;
    enc_nbits = 0;
  endtask

  // pack one code at the width the decoder will use, then track what it does
  task automatic put_code(input int unsigned code);
    int unsigned slen;
    if (enc_halted) return;
    enc_acc = enc_acc | (code << enc_nbits);
    enc_nbits += enc_width;
    while (enc_nbits >= 8) begin
      send_item(enc_acc[7:0], enc_first);
      enc_first = 1'b0;
      enc_acc = enc_acc >> 8;
      enc_nbits -= 8;
    end
    if (enc_after_clear) begin
      enc_after_clear = 1'b0;
      enc_prev_len = 1;
    end else if (code == CODE_END) begin
      enc_halted = 1'b1;
    end else if (code == CODE_CLEAR) begin
      enc_next = FIRST_FREE;
      enc_width = MIN_WIDTH;
      enc_after_clear = 1'b1;
    end else begin
      if (code < 256) slen = 1;
      else if (code < enc_next) slen = enc_len[code];
      else slen = enc_prev_len + 1;
      if (slen > STACK_SIZE) begin
        enc_halted = 1'b1;
      end else begin
        if (enc_next < DICT_SIZE) begin
          enc_len[enc_next] = enc_prev_len + 1;
          enc_next++;
          if (enc_next >= (1 << enc_width) && enc_width < clamp_width(dec_max_bits))
            enc_width++;
        end
        enc_prev_len = slen;
      end
    end
  endtask

  // flush the partial byte; with noise the pad bits are random
  task automatic stream_end(input bit noisy);
    if (noisy) begin
      enc_acc = enc_acc | ($urandom_range(0, 255) << enc_nbits);
      send_item(enc_acc[7:0], enc_first);
    end else if (enc_nbits > 0) begin
      send_item(enc_acc[7:0], enc_first);
    end
    enc_nbits = 0;
    enc_acc = 0;
  endtask

  // an undefined code is only ever the next free one, so no chain reaches an empty entry
  function automatic int unsigned pick_code();
    int r;
    if (enc_after_clear) return $urandom_range(0, 255);
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 255);
    if (r < 75) return (enc_next > FIRST_FREE) ? $urandom_range(FIRST_FREE, enc_next - 1)
                                               : $urandom_range(0, 255);
    if (r < 87) return (enc_next < DICT_SIZE) ? enc_next : $urandom_range(0, 255);
    if (r < 94) return CODE_CLEAR;
    return $urandom_range(0, 1) ? 255 : 0;
  endfunction

  task automatic test_directed();
    set_max_bits(MAX_WIDTH);
    stream_begin();
    put_code(255);          // first code of a stream: entry gets prefix 0
    put_code(0);
    put_code(258);
    put_code(261);          // code equal to next free entry
    put_code(300);          // code beyond next free entry
    put_code(CODE_CLEAR);
    put_code(CODE_END);     // literal after clear, even though it is the end code
    put_code(CODE_END);
    stream_end(1'b0);
    send_item(8'hFF, 1'b0); // halted: ignored
    send_item(8'h00, 1'b0);
    stream_begin();
    put_code(8'hAA);
    put_code(CODE_CLEAR);
    put_code(CODE_CLEAR);   // clear code taken as a literal
    put_code(CODE_CLEAR);
    put_code(8'h41);
    put_code(8'h42);
    put_code(CODE_END);
    stream_end(1'b0);
  endtask

  task automatic test_long_string();
    set_max_bits(4'd10);
    stream_begin();
    put_code(8'h07);
    // each repeat grows the string by one until it no longer fits the stack
    while (!enc_halted) put_code(enc_next);
    stream_end(1'b0);
  endtask

  task automatic test_backpressure();
    set_max_bits(4'd11);
    idle_on = 1'b0;
    hold_left = 400;
    stream_begin();
    put_code(8'h31);
    repeat (40) put_code(enc_next > 270 ? $urandom_range(FIRST_FREE, enc_next - 1) : enc_next);
    put_code(CODE_END);
    stream_end(1'b0);
    wait_drain();
  endtask

  task automatic test_random();
    int unsigned phase_start;
    int n;
    logic [3:0] widths[4];
    widths = '{4'd9, 4'd12, 4'd10, 4'd11};
    phase_start = items_sent;
    for (int p = 0; p < 4; p++) begin
      set_max_bits(widths[p]);
      idle_on = (p < 3);
      while (items_sent - phase_start < 10 * (p + 1)) begin
        stream_begin();
        n = $urandom_range(3, 10);
        for (int i = 0; i < n && !enc_halted; i++) put_code(pick_code());
        if ($urandom_range(0, 6) == 0) put_code(CODE_END);
        stream_end($urandom_range(0, 9) == 0);
        if (enc_halted && $urandom_range(0, 3) == 0) send_item($urandom_range(0, 255), 1'b0);
      end
    end
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected item", out_byte, 0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
        if (out_byte_valid !== want.data_ok)
          report_mismatch("byte_valid", out_byte_valid, want.data_ok);
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    dec_max_bits = CFG_RESET;
    restart_decoder();
    for (int i = 0; i < DICT_SIZE; i++) dec_dict[i] = 20'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_long_string();
    test_backpressure();
    test_random();
    idle_on = 1'b0;
    wait_drain();
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== lzw_variable_width_decoder_core.f =====
sv/lzwd_pkg.sv
sv/lzwd_ctrl.sv
sv/lzwd_dp.sv
sv/lzw_variable_width_decoder_core.sv
tb/sv/tb_top.sv
